// File: rtl/dtp_pkg.sv
// shared types, keyword table and codes for the declaration token parser
package dtp_pkg;

    localparam int MAX_LEN    = 255;
    localparam int POS_W      = 9;
    localparam int KW_COUNT   = 18;
    localparam int KW_MAXLEN  = 12;
    localparam int NUM_CLASS  = 6;

    localparam logic [KW_COUNT-1:0] KW_ALL = '1;

    localparam logic [KW_MAXLEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        "constant", "uniform", "varying", "vertex", "facevarying", "facevertex",
        "float", "point", "color", "integer", "int", "string", "vector",
        "normal", "hpoint", "pointer", "matrix", "mpoint"
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd8, 4'd7, 4'd7, 4'd6, 4'd11, 4'd10, 4'd5, 4'd5, 4'd5,
        4'd7, 4'd3, 4'd6, 4'd6, 4'd6, 4'd6, 4'd7, 4'd6, 4'd6
    };
    localparam logic [3:0] KW_CODE [KW_COUNT] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd0, 4'd1, 4'd2,
        4'd3, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10
    };

    typedef enum logic [3:0] {
        ST_OK        = 4'd0,
        ST_NO_NAME   = 4'd1,
        ST_NO_TYPE   = 4'd2,
        ST_NO_SIZE   = 4'd3,
        ST_BAD_SIZE  = 4'd4,
        ST_NO_CLOSE  = 4'd5,
        ST_BAD_CLOSE = 4'd6,
        ST_TOO_MANY  = 4'd7,
        ST_TOO_LONG  = 4'd8
    } t_status;

    typedef enum logic [6:0] {
        PH_FIRST       = 7'b0000001,
        PH_AFTER_CLASS = 7'b0000010,
        PH_AFTER_TYPE  = 7'b0000100,
        PH_SIZE        = 7'b0001000,
        PH_CLOSE       = 7'b0010000,
        PH_AFTER_ARRAY = 7'b0100000,
        PH_AFTER_NAME  = 7'b1000000
    } t_phase;

    typedef enum logic [1:0] {
        SZ_LEAD   = 2'd0,
        SZ_SIGN   = 2'd1,
        SZ_DIGITS = 2'd2,
        SZ_BAD    = 2'd3
    } t_size_syn;

    typedef enum logic [1:0] {
        TK_WORD  = 2'd0,
        TK_OPEN  = 2'd1,
        TK_CLOSE = 2'd2
    } t_tok_kind;

    typedef struct packed {
        logic       hit;
        logic       is_class;
        logic [3:0] code;
    } t_kw_hit;

    typedef struct packed {
        t_phase      phase;
        t_status     err;
        logic        f_class;
        logic        f_type;
        logic        f_array;
        logic        f_name;
        logic [2:0]  cls;
        logic [3:0]  typ;
        logic [31:0] size_val;
        logic [7:0]  name_b;
        logic [7:0]  name_e;
    } t_parse;

    localparam t_parse PS_IDLE = '{
        phase: PH_FIRST, err: ST_OK, f_class: 1'b0, f_type: 1'b0, f_array: 1'b0,
        f_name: 1'b0, cls: 3'd0, typ: 4'd0, size_val: 32'd0, name_b: 8'd0,
        name_e: 8'd0
    };

    function automatic logic [7:0] kw_char(int k, logic [3:0] idx);
        int sh;
        sh = (int'(KW_LEN[k]) - 1 - int'(idx)) * 8;
        if (idx >= KW_LEN[k]) return 8'd0;
        return KW_TEXT[k][sh +: 8];
    endfunction

endpackage

// File: rtl/declaration_token_parser_top.sv
// top level: character-stream declaration parser with registered result
// One character is taken per cycle whenever the result register is free or being
// drained, and each string ends with its zero terminator.
// Each character updates the keyword mask, size accumulator and grammar phase in
// a single pass; the zero terminator loads the result register, which then
// presents status and fields until the transaction completes. Strings longer
// than 255 characters report status 8 with all other fields zero.
module declaration_token_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_ch,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_status,
    output logic        o_has_class,
    output logic [2:0]  o_class_code,
    output logic        o_has_type,
    output logic [3:0]  o_type_code,
    output logic        o_has_array,
    output logic signed [31:0] o_dim_size,
    output logic        o_has_name,
    output logic [7:0]  o_name_start,
    output logic [7:0]  o_name_end
);
    import dtp_pkg::*;

    logic                r_name_req;
    t_parse              r_ps, n_ps;
    logic                r_inside, n_inside;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic [7:0]          r_tbeg, n_tbeg;
    logic [3:0]          r_tlen, n_tlen;
    logic [KW_COUNT-1:0] r_mask, n_mask;
    logic [31:0]         r_acc, n_acc;
    logic                r_neg, n_neg;
    t_size_syn           r_syn, n_syn;

    logic                r_out_valid;
    logic [3:0]          r_status;
    logic                r_has_class, r_has_type, r_has_array, r_has_name;
    logic [2:0]          r_class_code;
    logic [3:0]          r_type_code;
    logic [31:0]         r_dim_size;
    logic [7:0]          r_name_start, r_name_end;

    logic                accept, term;
    logic [KW_COUNT-1:0] mask_fed;
    t_kw_hit             hit;
    t_parse              fin;
    logic [35:0]         mul;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign term       = (i_ch == 8'd0);

    dtp_kw_match u_kw (
        .i_mask      (r_mask),
        .i_len       (r_tlen),
        .i_fresh     (!r_inside),
        .i_ch        (i_ch),
        .o_mask_next (mask_fed),
        .o_hit       (hit)
    );

    function automatic t_parse take_tok(t_parse s_in, t_tok_kind kind, t_kw_hit kh,
                                        t_size_syn syn, logic neg, logic [31:0] acc,
                                        logic [7:0] b, logic [7:0] e);
        t_parse s;
        logic   tt, ta, tn, kw;
        s  = s_in;
        tt = 1'b0;
        ta = 1'b0;
        tn = 1'b0;
        kw = kh.hit && (kind == TK_WORD);
        if (s.err != ST_OK) return s;
        unique case (s.phase)
            PH_FIRST: begin
                if (kw && kh.is_class) begin
                    s.f_class = 1'b1;
                    s.cls     = kh.code[2:0];
                    s.phase   = PH_AFTER_CLASS;
                    return s;
                end
                tt = 1'b1;
            end
            PH_AFTER_CLASS: tt = 1'b1;
            PH_AFTER_TYPE:  ta = 1'b1;
            PH_AFTER_ARRAY: tn = 1'b1;
            PH_SIZE: begin
                if (kind == TK_WORD && syn == SZ_DIGITS) begin
                    if (neg)
                        s.size_val = (acc >= 32'h8000_0000) ? 32'h8000_0000 : 32'd0 - acc;
                    else
                        s.size_val = (acc > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc;
                    s.phase = PH_CLOSE;
                end else begin
                    s.err = ST_BAD_SIZE;
                end
                return s;
            end
            PH_CLOSE: begin
                if (kind == TK_CLOSE) begin
                    s.f_array = 1'b1;
                    s.phase   = PH_AFTER_ARRAY;
                end else begin
                    s.err = ST_NO_CLOSE;
                end
                return s;
            end
            default: begin
                s.err = ST_TOO_MANY;
                return s;
            end
        endcase
        if (tt) begin
            if (kw && !kh.is_class) begin
                s.f_type = 1'b1;
                s.typ    = kh.code;
                s.phase  = PH_AFTER_TYPE;
                return s;
            end
            ta = 1'b1;
        end
        if (ta) begin
            if (kind == TK_OPEN) begin
                s.phase = PH_SIZE;
                return s;
            end
            tn = 1'b1;
        end
        if (tn) begin
            if (kind == TK_CLOSE) begin
                s.err = ST_BAD_CLOSE;
                return s;
            end
            s.f_name = 1'b1;
            s.name_b = b;
            s.name_e = e;
            s.phase  = PH_AFTER_NAME;
            if (!s.f_type && (s.f_class || s.f_array)) s.err = ST_NO_TYPE;
        end
        return s;
    endfunction

    // accumulator times ten plus digit, held at 2^31
    assign mul = {4'd0, r_inside ? r_acc : 32'd0} * 36'd10 + 36'(i_ch - 8'd48);

    always_comb begin
        n_ps     = r_ps;
        n_inside = r_inside;
        n_pos    = r_pos;
        n_tbeg   = r_tbeg;
        n_tlen   = r_tlen;
        n_mask   = r_mask;
        n_acc    = r_acc;
        n_neg    = r_neg;
        n_syn    = r_syn;
        fin      = r_ps;
        if (!term) begin
            if (r_ps.err == ST_TOO_LONG) begin
                n_pos = r_pos;
            end else if (r_pos >= POS_W'(MAX_LEN)) begin
                n_ps.err = ST_TOO_LONG;
            end else begin
                priority if (i_ch == 8'd32 || i_ch == 8'd9 || i_ch == 8'd10) begin
                    if (r_inside)
                        n_ps = take_tok(r_ps, TK_WORD, hit, r_syn, r_neg, r_acc,
                                        r_tbeg, r_pos[7:0]);
                    n_inside = 1'b0;
                end else if (i_ch == 8'd91 || i_ch == 8'd93) begin
                    if (r_inside)
                        n_ps = take_tok(r_ps, TK_WORD, hit, r_syn, r_neg, r_acc,
                                        r_tbeg, r_pos[7:0]);
                    n_ps = take_tok(n_ps, (i_ch == 8'd91) ? TK_OPEN : TK_CLOSE, hit,
                                    r_syn, r_neg, r_acc, r_pos[7:0], 8'(r_pos + 1'b1));
                    n_inside = 1'b0;
                end else begin
                    t_size_syn syn_in;
                    syn_in   = r_inside ? r_syn : SZ_LEAD;
                    n_inside = 1'b1;
                    if (!r_inside) begin
                        n_tbeg = r_pos[7:0];
                        n_acc  = 32'd0;
                        n_neg  = 1'b0;
                    end
                    n_mask = mask_fed;
                    n_tlen = (r_inside && r_tlen >= 4'(KW_MAXLEN)) ? r_tlen
                             : (r_inside ? r_tlen + 4'd1 : 4'd1);
                    n_syn  = syn_in;
                    priority if (i_ch >= 8'd48 && i_ch <= 8'd57 && syn_in != SZ_BAD) begin
                        n_acc = (mul > 36'h0_8000_0000) ? 32'h8000_0000 : mul[31:0];
                        n_syn = SZ_DIGITS;
                    end else if (syn_in == SZ_LEAD &&
                                 (i_ch == 8'd11 || i_ch == 8'd12 || i_ch == 8'd13)) begin
                        n_syn = SZ_LEAD;
                    end else if (syn_in == SZ_LEAD && (i_ch == 8'd43 || i_ch == 8'd45)) begin
                        n_neg = (i_ch == 8'd45);
                        n_syn = SZ_SIGN;
                    end else begin
                        n_syn = SZ_BAD;
                    end
                end
                n_pos = r_pos + 1'b1;
            end
        end else begin
            if (r_ps.err != ST_TOO_LONG) begin
                if (r_inside)
                    fin = take_tok(r_ps, TK_WORD, hit, r_syn, r_neg, r_acc,
                                   r_tbeg, r_pos[7:0]);
                if (fin.err == ST_OK) begin
                    unique case (fin.phase)
                        PH_SIZE:       fin.err = ST_NO_SIZE;
                        PH_CLOSE:      fin.err = ST_NO_CLOSE;
                        PH_AFTER_NAME: fin.err = ST_OK;
                        default: begin
                            if (r_name_req)
                                fin.err = ST_NO_NAME;
                            else if (!fin.f_type && (fin.f_class || fin.f_array))
                                fin.err = ST_NO_TYPE;
                        end
                    endcase
                end
            end
            n_ps       = '0;
            n_ps.phase = PH_FIRST;
            n_ps.err   = ST_OK;
            n_inside   = 1'b0;
            n_pos      = '0;
            n_tbeg     = '0;
            n_tlen     = '0;
            n_mask     = KW_ALL;
            n_acc      = '0;
            n_neg      = 1'b0;
            n_syn      = SZ_LEAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_req       <= 1'b0;
            r_ps             <= PS_IDLE;
            r_inside         <= 1'b0;
            r_pos            <= '0;
            r_tbeg           <= '0;
            r_tlen           <= '0;
            r_mask           <= KW_ALL;
            r_acc            <= '0;
            r_neg            <= 1'b0;
            r_syn            <= SZ_LEAD;
            r_out_valid      <= 1'b0;
        end else begin
            if (i_cfg_we) r_name_req <= i_cfg_wdata;
            if (accept) begin
                r_ps     <= n_ps;
                r_inside <= n_inside;
                r_pos    <= n_pos;
                r_tbeg   <= n_tbeg;
                r_tlen   <= n_tlen;
                r_mask   <= n_mask;
                r_acc    <= n_acc;
                r_neg    <= n_neg;
                r_syn    <= n_syn;
            end
            if (accept && term)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
        end
    end

    // result register, fields zeroed when their part is absent or the string is too long
    always_ff @(posedge i_clk) begin
        if (accept && term) begin
            logic ok;
            ok = (fin.err != ST_TOO_LONG);
            r_status     <= fin.err;
            r_has_class  <= ok && fin.f_class;
            r_class_code <= (ok && fin.f_class) ? fin.cls : 3'd0;
            r_has_type   <= ok && fin.f_type;
            r_type_code  <= (ok && fin.f_type) ? fin.typ : 4'd0;
            r_has_array  <= ok && fin.f_array;
            r_dim_size   <= (ok && fin.f_array) ? fin.size_val : 32'd0;
            r_has_name   <= ok && fin.f_name;
            r_name_start <= (ok && fin.f_name) ? fin.name_b : 8'd0;
            r_name_end   <= (ok && fin.f_name) ? fin.name_e : 8'd0;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_has_class  = r_has_class;
    assign o_class_code = r_class_code;
    assign o_has_type   = r_has_type;
    assign o_type_code  = r_type_code;
    assign o_has_array  = r_has_array;
    assign o_dim_size   = r_dim_size;
    assign o_has_name   = r_has_name;
    assign o_name_start = r_name_start;
    assign o_name_end   = r_name_end;

`ifndef ASSERT_OFF
    a_term_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && term) |=> o_out_valid)
        else $error("terminator did not load a result");

    a_term_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && term) |=> (r_pos == '0 && !r_inside))
        else $error("parse state not cleared after terminator");

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(MAX_LEN))
        else $error("character position beyond limit");

    a_no_name_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_name) |-> (o_name_start == 8'd0 && o_name_end == 8'd0))
        else $error("name span set without a name");
`endif

endmodule

// File: rtl/dtp_kw_match.sv
// keyword candidate mask update and end-of-token keyword lookup
module dtp_kw_match (
    input  logic [dtp_pkg::KW_COUNT-1:0] i_mask,
    input  logic [3:0]                   i_len,
    input  logic                         i_fresh,
    input  logic [7:0]                   i_ch,
    output logic [dtp_pkg::KW_COUNT-1:0] o_mask_next,
    output dtp_pkg::t_kw_hit             o_hit
);
    import dtp_pkg::*;

    logic [KW_COUNT-1:0] mask_in;
    logic [3:0]          len_in;
    logic [7:0]          low;

    assign mask_in = i_fresh ? KW_ALL : i_mask;
    assign len_in  = i_fresh ? 4'd0 : i_len;
    // fold A..Z only
    assign low = (i_ch >= 8'd65 && i_ch < 8'd91) ? i_ch + 8'd32 : i_ch;

    always_comb begin
        for (int k = 0; k < KW_COUNT; k++) begin
            o_mask_next[k] = mask_in[k] && (len_in < KW_LEN[k]) &&
                             (len_in < 4'(KW_MAXLEN)) && (kw_char(k, len_in) == low);
        end
    end

    // lowest matching index wins
    always_comb begin
        o_hit = '0;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (i_mask[k] && KW_LEN[k] == i_len) begin
                o_hit.hit      = 1'b1;
                o_hit.is_class = (k < NUM_CLASS);
                o_hit.code     = KW_CODE[k];
            end
        end
    end

endmodule

// File: tb/declaration_token_parser_checker.sv
// checker: watches the parser channels, predicts each declaration result and compares
`timescale 1ns / 100ps
module declaration_token_parser_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_ch,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [3:0]  i_status,
    input  logic        i_has_class,
    input  logic [2:0]  i_class_code,
    input  logic        i_has_type,
    input  logic [3:0]  i_type_code,
    input  logic        i_has_array,
    input  logic [31:0] i_dim_size,
    input  logic        i_has_name,
    input  logic [7:0]  i_name_start,
    input  logic [7:0]  i_name_end,
    output int          o_fail_count,
    output int          o_pending
);
    import dtp_pkg::*;

    typedef struct packed {
        logic [3:0]  status;
        logic        has_class;
        logic [2:0]  class_code;
        logic        has_type;
        logic [3:0]  type_code;
        logic        has_array;
        logic [31:0] dim_size;
        logic        has_name;
        logic [7:0]  name_start;
        logic [7:0]  name_end;
    } t_decl;

    localparam int FL_CLASS = 0;
    localparam int FL_TYPE  = 1;
    localparam int FL_ARRAY = 2;
    localparam int FL_NAME  = 3;

    // word list kept locally, class words first
    string       words [KW_COUNT] = '{"constant", "uniform", "varying", "vertex",
        "facevarying", "facevertex", "float", "point", "color", "integer", "int",
        "string", "vector", "normal", "hpoint", "pointer", "matrix", "mpoint"};
    int          word_code [KW_COUNT] = '{0, 1, 2, 3, 4, 5, 0, 1, 2, 3, 3, 4, 5, 6,
        7, 8, 9, 10};

    t_decl       decl_q[$];
    logic        need_name;
    t_phase      phase;
    logic        in_tok;
    int          pos, tok_b, tok_len;
    logic [KW_COUNT-1:0] cands;
    logic [31:0] acc, size_val;
    logic        neg;
    t_size_syn   syn;
    logic [3:0]  found;
    logic [2:0]  cls;
    logic [3:0]  typ;
    logic [7:0]  nm_b, nm_e;
    t_status     err;

    function automatic void clear_decl();
        phase = PH_FIRST; in_tok = 0; pos = 0; tok_b = 0; tok_len = 0;
        cands = '1; acc = 0; neg = 0; syn = SZ_LEAD; found = 0; cls = 0;
        typ = 0; size_val = 0; nm_b = 0; nm_e = 0; err = ST_OK;
    endfunction

    function automatic void feed(logic [7:0] c);
        logic [7:0] low;
        logic [63:0] m;
        low = (c >= 8'd65 && c < 8'd91) ? c + 8'd32 : c;
        for (int k = 0; k < KW_COUNT; k++)
            if (tok_len >= words[k].len() || tok_len >= 12 || words[k][tok_len] != low)
                cands[k] = 0;
        if (tok_len < 12) tok_len++;
        if (c >= "0" && c <= "9" && syn != SZ_BAD) begin
            m = 64'(acc) * 10 + 64'(c - "0");
            if (m > 64'h8000_0000) m = 64'h8000_0000;
            acc = m[31:0];
            syn = SZ_DIGITS;
        end else if (syn == SZ_LEAD && (c == 11 || c == 12 || c == 13)) begin
        end else if (syn == SZ_LEAD && (c == "+" || c == "-")) begin
            neg = (c == "-");
            syn = SZ_SIGN;
        end else begin
            syn = SZ_BAD;
        end
    endfunction

    function automatic void take(t_tok_kind kind, int b, int e);
        int kw;
        kw = -1;
        if (kind == TK_WORD)
            for (int k = KW_COUNT - 1; k >= 0; k--)
                if (cands[k] && words[k].len() == tok_len) kw = k;
        if (err != ST_OK) return;
        case (phase)
            PH_SIZE: begin
                if (kind == TK_WORD && syn == SZ_DIGITS) begin
                    if (neg) size_val = (acc >= 32'h8000_0000) ? 32'h8000_0000 : -acc;
                    else size_val = (acc > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : acc;
                    phase = PH_CLOSE;
                end else err = ST_BAD_SIZE;
                return;
            end
            PH_CLOSE: begin
                if (kind == TK_CLOSE) begin
                    found[FL_ARRAY] = 1;
                    phase = PH_AFTER_ARRAY;
                end else err = ST_NO_CLOSE;
                return;
            end
            PH_AFTER_NAME: begin
                err = ST_TOO_MANY;
                return;
            end
            default: ;
        endcase
        if (phase == PH_FIRST && kw >= 0 && kw < NUM_CLASS) begin
            found[FL_CLASS] = 1;
            cls = 3'(word_code[kw]);
            phase = PH_AFTER_CLASS;
            return;
        end
        if ((phase == PH_FIRST || phase == PH_AFTER_CLASS) && kw >= NUM_CLASS) begin
            found[FL_TYPE] = 1;
            typ = 4'(word_code[kw]);
            phase = PH_AFTER_TYPE;
            return;
        end
        if (phase != PH_AFTER_ARRAY && kind == TK_OPEN) begin
            phase = PH_SIZE;
            return;
        end
        if (kind == TK_CLOSE) begin
            err = ST_BAD_CLOSE;
            return;
        end
        found[FL_NAME] = 1;
        nm_b = 8'(b); nm_e = 8'(e);
        phase = PH_AFTER_NAME;
        if (!found[FL_TYPE] && (found[FL_CLASS] || found[FL_ARRAY])) err = ST_NO_TYPE;
    endfunction

    function automatic void parse_char(logic [7:0] c);
        t_decl r;
        if (c != 0) begin
            if (err == ST_TOO_LONG) return;
            if (pos >= MAX_LEN) begin
                err = ST_TOO_LONG;
                return;
            end
            if (c == " " || c == "\t" || c == "\n" || c == "[" || c == "]") begin
                if (in_tok) begin
                    take(TK_WORD, tok_b, pos);
                    in_tok = 0;
                end
                if (c == "[") take(TK_OPEN, pos, pos + 1);
                if (c == "]") take(TK_CLOSE, pos, pos + 1);
            end else begin
                if (!in_tok) begin
                    in_tok = 1; tok_b = pos; tok_len = 0; cands = '1;
                    acc = 0; neg = 0; syn = SZ_LEAD;
                end
                feed(c);
            end
            pos++;
            return;
        end
        if (err != ST_TOO_LONG) begin
            if (in_tok) begin
                take(TK_WORD, tok_b, pos);
                in_tok = 0;
            end
            if (err == ST_OK)
                case (phase)
                    PH_SIZE:  err = ST_NO_SIZE;
                    PH_CLOSE: err = ST_NO_CLOSE;
                    PH_AFTER_NAME: ;
                    default:
                        if (need_name) err = ST_NO_NAME;
                        else if (!found[FL_TYPE] && (found[FL_CLASS] || found[FL_ARRAY]))
                            err = ST_NO_TYPE;
                endcase
        end
        r = '0;
        r.status = err;
        if (err != ST_TOO_LONG) begin
            if (found[FL_CLASS]) begin r.has_class = 1; r.class_code = cls; end
            if (found[FL_TYPE])  begin r.has_type = 1;  r.type_code = typ; end
            if (found[FL_ARRAY]) begin r.has_array = 1; r.dim_size = size_val; end
            if (found[FL_NAME])  begin
                r.has_name = 1; r.name_start = nm_b; r.name_end = nm_e;
            end
        end
        decl_q.push_back(r);
        clear_decl();
    endfunction

    always @(posedge i_clk) begin
        t_decl got, want;
        if (!i_rst_n) begin
            need_name = 0;
            clear_decl();
            decl_q.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_we) need_name = i_cfg_wdata;
            if (i_in_valid && i_in_ready) parse_char(i_ch);
            if (i_out_valid && i_out_ready) begin
                got = '{i_status, i_has_class, i_class_code, i_has_type, i_type_code,
                        i_has_array, i_dim_size, i_has_name, i_name_start, i_name_end};
                if (decl_q.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, got);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = decl_q.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch expected st=%0d c=%0d/%0d t=%0d/%0d a=%0d/%0d n=%0d/%0d/%0d",
                            $time, want.status, want.has_class, want.class_code,
                            want.has_type, want.type_code, want.has_array,
                            $signed(want.dim_size), want.has_name, want.name_start,
                            want.name_end);
                        $display("%0t: mismatch actual   st=%0d c=%0d/%0d t=%0d/%0d a=%0d/%0d n=%0d/%0d/%0d",
                            $time, got.status, got.has_class, got.class_code,
                            got.has_type, got.type_code, got.has_array,
                            $signed(got.dim_size), got.has_name, got.name_start,
                            got.name_end);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= decl_q.size();
    end

endmodule

// File: tb/declaration_token_parser_top_test.sv
// testbench top: drives declaration strings and configuration, gives the verdict
`timescale 1ns / 100ps
module declaration_token_parser_top_test;
    import dtp_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic        cfg_wdata = 0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [7:0]  ch = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [3:0]  status;
    logic        has_class, has_type, has_array, has_name;
    logic [2:0]  class_code;
    logic [3:0]  type_code;
    logic signed [31:0] dim_size;
    logic [7:0]  name_start, name_end;
    int          fail_count, pending;
    int          send_idle_pct = 7, recv_idle_pct = 57;
    bit          recv_hold = 0;
    int          idle_cycles = 0;

    always begin
        #2 clk = 1;
        #2 clk = 0;
    end

    declaration_token_parser_top dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_ch(ch),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_status(status),
        .o_has_class(has_class), .o_class_code(class_code), .o_has_type(has_type),
        .o_type_code(type_code), .o_has_array(has_array), .o_dim_size(dim_size),
        .o_has_name(has_name), .o_name_start(name_start), .o_name_end(name_end)
    );

    declaration_token_parser_checker decl_check (
        .i_clk(clk), .i_rst_n(rst_n), .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_ch(ch),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_status(status),
        .i_has_class(has_class), .i_class_code(class_code), .i_has_type(has_type),
        .i_type_code(type_code), .i_has_array(has_array), .i_dim_size(dim_size),
        .i_has_name(has_name), .i_name_start(name_start), .i_name_end(name_end),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // receiver side: random stalls, or a long hold-off when asked
    always @(posedge clk) begin
        if (!rst_n) out_ready <= 0;
        else out_ready <= !recv_hold && ($urandom_range(99, 0) >= recv_idle_pct);
    end

    // watchdog on cycles with no transaction
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // valid stays up between back-to-back characters; it drops only for idle gaps
    task automatic send_char(logic [7:0] c);
        if ($urandom_range(99, 0) < send_idle_pct) begin
            in_valid <= 0;
            do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
        end
        in_valid <= 1;
        ch <= c;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i]);
        send_char(8'd0);
    endtask

    task automatic drain();
        in_valid <= 0;
        do @(posedge clk); while (pending != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(logic v);
        drain();
        cfg_we <= 1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 0;
    endtask

    function automatic string mix_case(string s);
        string r;
        r = s;
        for (int i = 0; i < r.len(); i++)
            if ($urandom_range(1, 0) && r[i] >= "a" && r[i] <= "z") r[i] = r[i] - 32;
        return r;
    endfunction

    function automatic string pick_sep();
        case ($urandom_range(5, 0))
            0: return "\t";
            1: return "\n";
            2: return "  ";
            default: return " ";
        endcase
    endfunction

    function automatic string rand_size();
        string s;
        s = "";
        repeat ($urandom_range(2, 0) == 0 ? $urandom_range(2, 1) : 0)
            s = {s, string'(8'($urandom_range(13, 11)))};
        case ($urandom_range(3, 0))
            0: s = {s, "-"};
            1: s = {s, "+"};
            default: ;
        endcase
        repeat ($urandom_range(3, 0) == 0 ? $urandom_range(14, 10) : $urandom_range(3, 1))
            s = {s, string'(8'($urandom_range(57, 48)))};
        if ($urandom_range(15, 0) == 0) s = {s, "x"};
        return s;
    endfunction

    function automatic string rand_ident();
        string s;
        s = "";
        repeat ($urandom_range(6, 1)) s = {s, string'(8'($urandom_range(122, 97)))};
        return s;
    endfunction

    function automatic string rand_decl();
        string kw [18] = '{"constant", "uniform", "varying", "vertex", "facevarying",
            "facevertex", "float", "point", "color", "integer", "int", "string",
            "vector", "normal", "hpoint", "pointer", "matrix", "mpoint"};
        string s;
        s = ($urandom_range(3, 0) == 0) ? pick_sep() : "";
        if ($urandom_range(1, 0)) s = {s, mix_case(kw[$urandom_range(5, 0)]), pick_sep()};
        if ($urandom_range(4, 0) != 0)
            s = {s, mix_case(kw[$urandom_range(17, 6)]), pick_sep()};
        if ($urandom_range(1, 0)) s = {s, "[", pick_sep(), rand_size(), "]"};
        if ($urandom_range(4, 0) != 0) s = {s, pick_sep(), rand_ident()};
        if ($urandom_range(7, 0) == 0) s = {s, pick_sep(), rand_ident()};
        if ($urandom_range(9, 0) == 0) s = {s, "]"};
        return s;
    endfunction

    function automatic string rand_noise();
        string s;
        s = "";
        repeat ($urandom_range(12, 1)) s = {s, string'(8'($urandom_range(255, 1)))};
        return s;
    endfunction

    initial begin
        string long_s;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed strings
        send_text("uniform float [3] x");
        send_text("CONSTANT Int[-2147483648]n");
        send_text("varying color [99999999999] c");
        send_text("facevarying vector[\v\f\r+12]abc");
        send_text("facevertex hpoint v");
        send_text("vertex mpoint [4 nm");
        send_text("matrix [ ]");
        send_text("pointer [");
        send_text("normal [1x] q");
        send_text("uniform nm");
        send_text("string a b");
        send_text("]");
        send_text("point\tp\n");
        send_text("integer");
        send_text("");
        send_text({"float ", {8'hff, 8'h80}});
        long_s = "";
        repeat (260) long_s = {long_s, "a"};
        send_text(long_s);
        write_cfg(1);
        send_text("float");
        send_text("uniform float q");
        send_text("");

        // random phases with both idle patterns, then none
        for (int ph = 0; ph < 3; ph++) begin
            if (ph == 1) begin send_idle_pct = 57; recv_idle_pct = 7; end
            if (ph == 2) begin send_idle_pct = 0; recv_idle_pct = 0; end
            write_cfg(ph == 1);
            if (ph == 1) begin
                // receiver holds off while the sender keeps offering
                recv_hold <= 1;
                fork
                    begin repeat (200) @(posedge clk); recv_hold <= 0; end
                    repeat (12) send_text("int[2] z");
                join
            end
            for (int n = 0; n < 6; n++) begin
                if ($urandom_range(5, 0) == 0) send_text(rand_noise());
                else send_text(rand_decl());
            end
        end
        write_cfg(0);
        drain();
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: filelist.f
rtl/dtp_pkg.sv
rtl/dtp_kw_match.sv
rtl/declaration_token_parser_top.sv
tb/declaration_token_parser_checker.sv
tb/declaration_token_parser_top_test.sv
